### hdl/sorted_priority_queue_macros.svh
// Assertion macros for the sorted priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
// Property that holds at every clock edge outside reset.
`define SPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPQ_ASSERT(label, clk, rst_n, prop, msg)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/spq_pkg.sv
// Types and codes shared by the sorted priority queue modules.
`default_nettype none
package spq_pkg;

    // Request codes on the input word
    localparam logic [1:0] REQ_ENQ   = 2'd0;
    localparam logic [1:0] REQ_DEQ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Status codes on the result word
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // One stored entry
    typedef struct packed {
        logic [31:0]        payload;
        logic signed [15:0] prio;
    } t_entry;

    // Operation broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ENQ,
        CELL_DEQ
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_entry   new_entry;
    } t_cell_ctl;

endpackage
`default_nettype wire

### hdl/sorted_priority_queue.sv
// Sorted priority queue: top level with the cell chain, fill count and result register.
//
// Input channel (i_in_valid / o_in_ready) takes one request word: enqueue,
// dequeue of the head, or clear. Output channel (o_out_valid / i_out_ready)
// returns exactly one result word per request: status, the removed entry,
// the head after the request, the entry count and an empty flag.
// Each request is done in the cycle it is accepted; its result is registered
// and shows in the next cycle. One request per cycle is sustained while the
// receiver takes each result: every cell compares against the new priority
// and shifts by one slot in that same cycle, so the rate does not depend on
// DEPTH or on how full the queue is. A stalled receiver holds the result
// register; a new request is taken in the cycle the pending result is taken.
// Reset clears the fill count and the result valid flag; the slots are not
// cleared, since only slots below the count are ever read.
// entry_count reports the count masked to five bits.
`default_nettype none
`include "sorted_priority_queue_macros.svh"
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire  [1:0]         i_req_type,
    input  wire  [31:0]        i_payload,
    input  wire  signed [15:0] i_prio,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic [1:0]         o_status,
    output logic [31:0]        o_removed_payload,
    output logic signed [15:0] o_removed_prio,
    output logic [31:0]        o_head_payload,
    output logic signed [15:0] o_head_prio,
    output logic [4:0]         o_entry_count,
    output logic               o_is_empty
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [1:0]    n_status;
    t_entry        r_removed;
    t_entry        n_removed;
    t_entry        r_head;
    t_entry        n_head;
    logic          w_accept;
    logic          w_full;
    t_cell_ctl     w_ctl;
    t_entry        w_entry [DEPTH];
    t_entry        w_next  [DEPTH];
    logic          w_stay  [DEPTH];
    logic [CW+4:0] w_count_ext;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = r_count >= CW'(DEPTH);

    // Decode the request into a cell operation, next count and status
    always_comb begin
        w_ctl.op                = CELL_HOLD;
        w_ctl.new_entry.payload = i_payload;
        w_ctl.new_entry.prio    = i_prio;
        n_count                 = r_count;
        n_status                = ST_DONE;
        n_removed               = '0;
        if (w_accept) begin
            case (i_req_type)
                REQ_ENQ: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.op = CELL_ENQ;
                        n_count  = r_count + CW'(1);
                    end
                end
                REQ_DEQ: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_ctl.op  = CELL_DEQ;
                        n_count   = r_count - CW'(1);
                        n_removed = w_entry[0];
                    end
                end
                REQ_CLEAR: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_count = '0;
                    end
                end
                default: n_status = ST_DONE;
            endcase
        end
    end

    // Head after the request, zero when the queue ends up empty
    always_comb begin
        if (n_count == '0) begin
            n_head = '0;
        end else begin
            n_head = w_next[0];
        end
    end

    // Chain of cells, slot 0 is the head
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_stay;

        if (i == 0) begin : g_first
            assign w_left      = w_ctl.new_entry;
            assign w_left_stay = 1'b0;
        end else begin : g_rest
            assign w_left      = w_entry[i-1];
            assign w_left_stay = w_stay[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign w_right = w_entry[i];
        end else begin : g_inner
            assign w_right = w_entry[i+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (CW'(i) < r_count),
            .i_head      (i == 0),
            .i_left_stay (w_left_stay),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_entry     (w_entry[i]),
            .o_next      (w_next[i]),
            .o_stay      (w_stay[i])
        );
    end

    // Fill count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
            r_head    <= n_head;
        end
    end

    assign w_count_ext       = {5'd0, r_count};
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_removed_payload = r_removed.payload;
    assign o_removed_prio    = r_removed.prio;
    assign o_head_payload    = r_head.payload;
    assign o_head_prio       = r_head.prio;
    assign o_entry_count     = w_count_ext[4:0];
    assign o_is_empty        = (r_count == '0);

    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "count above depth")
    `SPQ_ASSERT_NEXT(a_enq_count, i_clk, i_rst_n, w_accept && (i_req_type == REQ_ENQ) && !w_full, r_count == $past(r_count) + CW'(1), "enqueue did not grow count")
    `SPQ_ASSERT_NEXT(a_deq_head, i_clk, i_rst_n, w_accept && (i_req_type == REQ_DEQ) && (r_count != '0), o_removed_prio == $past(w_entry[0].prio), "dequeue lost head")
    `SPQ_ASSERT(a_empty_head, i_clk, i_rst_n, !(o_out_valid && o_is_empty && !w_accept) || (o_head_prio == 16'sd0 && o_head_payload == 32'd0), "empty queue shows a head")

endmodule
`default_nettype wire

### hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts toward head or tail.
`default_nettype none
module spq_cell
    import spq_pkg::*;
(
    input  wire       i_clk,
    input  t_cell_ctl i_ctl,
    input  wire       i_occ,        // slot lies below the fill count
    input  wire       i_head,       // slot 0: ties stay ahead of the new entry
    input  wire       i_left_stay,  // neighbor toward head keeps its entry
    input  t_entry    i_left,
    input  t_entry    i_right,
    output t_entry    o_entry,
    output t_entry    o_next,
    output logic      o_stay
);

    t_entry r_entry;
    t_entry n_entry;

    // Entry stays in place on enqueue when it sorts ahead of the new one
    always_comb begin
        if (i_head) begin
            o_stay = i_occ && (r_entry.prio <= i_ctl.new_entry.prio);
        end else begin
            o_stay = i_occ && (r_entry.prio < i_ctl.new_entry.prio);
        end
    end

    // Next entry: keep, take the new word, or take a neighbor's entry
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            CELL_ENQ: begin
                if (o_stay) begin
                    n_entry = r_entry;
                end else if (i_head || i_left_stay) begin
                    n_entry = i_ctl.new_entry;
                end else begin
                    n_entry = i_left;
                end
            end
            CELL_DEQ: n_entry = i_right;
            default:  n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule
`default_nettype wire

### test/tb.sv
// Self-checking testbench for the sorted priority queue: random and directed request words.
`default_nettype none
module tb;
    import spq_pkg::*;

    localparam int QDEPTH = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD = 60;
    localparam int TAIL_CYCLES = 8;

    // Code 3 is not a request; the block answers it without touching the entries
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic signed [15:0] PRIO_MIN = 16'sh8000;
    localparam logic signed [15:0] PRIO_MAX = 16'sh7FFF;

    // Idle mixes: sender light and receiver heavy, then swapped, then none
    localparam int MIX_RX_SLOW = 0;
    localparam int MIX_TX_SLOW = 1;
    localparam int MIX_NO_IDLE = 2;

    typedef struct packed {
        logic [1:0]         req;
        logic [31:0]        payload;
        logic signed [15:0] prio;
    } t_request;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        rem_payload;
        logic signed [15:0] rem_prio;
        logic [31:0]        head_payload;
        logic signed [15:0] head_prio;
        logic [4:0]         count;
        logic               empty;
    } t_result;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic               drv_valid = 1'b0;
    logic [1:0]         drv_req = REQ_ENQ;
    logic [31:0]        drv_payload = '0;
    logic signed [15:0] drv_prio = '0;
    logic               rcv_ready = 1'b0;

    logic               o_in_ready;
    logic               o_out_valid;
    logic [1:0]         o_status;
    logic [31:0]        o_removed_payload;
    logic signed [15:0] o_removed_prio;
    logic [31:0]        o_head_payload;
    logic signed [15:0] o_head_prio;
    logic [4:0]         o_entry_count;
    logic               o_is_empty;

    sorted_priority_queue #(.DEPTH(QDEPTH)) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (drv_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (drv_req),
        .i_payload         (drv_payload),
        .i_prio            (drv_prio),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (rcv_ready),
        .o_status          (o_status),
        .o_removed_payload (o_removed_payload),
        .o_removed_prio    (o_removed_prio),
        .o_head_payload    (o_head_payload),
        .o_head_prio       (o_head_prio),
        .o_entry_count     (o_entry_count),
        .o_is_empty        (o_is_empty)
    );

    // Words waiting to be driven, and results owed by the block in order
    t_request req_backlog[$];
    t_result  pq_results_due[$];

    // Shadow copy of the sorted entries, slot 0 is the head
    logic [31:0]        shadow_payload [QDEPTH];
    logic signed [15:0] shadow_prio [QDEPTH];
    int                 shadow_len = 0;

    int idle_mix = MIX_RX_SLOW;
    int words_total = 0;
    int words_taken = 0;
    int results_checked = 0;
    int err_cnt = 0;

    // Coverage tallies for the closing summary
    int n_enq_ok = 0;
    int n_full = 0;
    int n_deq_ok = 0;
    int n_on_empty = 0;
    int n_clear = 0;
    int n_unused = 0;
    int peak_len = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Apply one request to the shadow queue and return the result it owes
    function automatic t_result pq_apply(input t_request r);
        t_result res;
        int      pos;
        int      k;
        res = '0;
        res.status = ST_DONE;
        case (r.req)
            REQ_ENQ: begin
                if (shadow_len >= QDEPTH) begin
                    res.status = ST_FULL;
                    n_full++;
                end else begin
                    // head only when strictly greater; later ties keep the new word first
                    if (shadow_len == 0 || shadow_prio[0] > r.prio) begin
                        pos = 0;
                    end else begin
                        pos = 1;
                        while (pos < shadow_len && shadow_prio[pos] < r.prio)
                            pos++;
                    end
                    for (k = shadow_len; k > pos; k--) begin
                        shadow_payload[k] = shadow_payload[k - 1];
                        shadow_prio[k] = shadow_prio[k - 1];
                    end
                    shadow_payload[pos] = r.payload;
                    shadow_prio[pos] = r.prio;
                    shadow_len++;
                    n_enq_ok++;
                end
            end
            REQ_DEQ: begin
                if (shadow_len == 0) begin
                    res.status = ST_EMPTY;
                    n_on_empty++;
                end else begin
                    res.rem_payload = shadow_payload[0];
                    res.rem_prio = shadow_prio[0];
                    for (k = 1; k < shadow_len; k++) begin
                        shadow_payload[k - 1] = shadow_payload[k];
                        shadow_prio[k - 1] = shadow_prio[k];
                    end
                    shadow_len--;
                    n_deq_ok++;
                end
            end
            REQ_CLEAR: begin
                if (shadow_len == 0) begin
                    res.status = ST_EMPTY;
                    n_on_empty++;
                end else begin
                    shadow_len = 0;
                    n_clear++;
                end
            end
            default: begin
                n_unused++;
            end
        endcase
        if (shadow_len > 0) begin
            res.head_payload = shadow_payload[0];
            res.head_prio = shadow_prio[0];
        end
        res.count = shadow_len[4:0];
        res.empty = (shadow_len == 0);
        if (shadow_len > peak_len)
            peak_len = shadow_len;
        return res;
    endfunction

    task automatic add_req(input logic [1:0] req, input logic [31:0] pay,
                           input logic signed [15:0] pr);
        req_backlog.push_back('{req, pay, pr});
        words_total++;
    endtask

    // Bursts biased toward filling, draining or mixing, so full and empty both occur often
    task automatic queue_random_words(input int n);
        int                 left;
        int                 burst;
        int                 mode;
        int                 roll;
        logic [1:0]         req;
        logic signed [15:0] pr;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(32, 12);
            if (burst > left)
                burst = left;
            mode = $urandom_range(2);
            repeat (burst) begin
                roll = $urandom_range(99);
                if (roll < 2)
                    req = REQ_CLEAR;
                else if (roll < 4)
                    req = REQ_UNUSED;
                else if (mode == 0)
                    req = (roll < 80) ? REQ_ENQ : REQ_DEQ;
                else if (mode == 1)
                    req = (roll < 30) ? REQ_ENQ : REQ_DEQ;
                else
                    req = (roll < 55) ? REQ_ENQ : REQ_DEQ;
                // narrow band gives plenty of ties; extremes and full range otherwise
                case ($urandom_range(9))
                    0: pr = PRIO_MIN;
                    1: pr = PRIO_MAX;
                    2, 3, 4, 5: pr = 16'($urandom_range(8) - 4);
                    default: pr = 16'($urandom);
                endcase
                add_req(req, $urandom, pr);
            end
            left -= burst;
        end
    endtask

    // Driver: offers the next word, predicts on each accepted one
    always @(posedge i_clk) begin : driver
        t_request nxt;
        int       idle_pct;
        idle_pct = (idle_mix == MIX_RX_SLOW) ? 13 : (idle_mix == MIX_TX_SLOW) ? 75 : 0;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && o_in_ready) begin
                pq_results_due.push_back(pq_apply('{drv_req, drv_payload, drv_prio}));
                words_taken <= words_taken + 1;
            end
            if (!drv_valid || o_in_ready) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    nxt = req_backlog.pop_front();
                    drv_valid <= 1'b1;
                    drv_req <= nxt.req;
                    drv_payload <= nxt.payload;
                    drv_prio <= nxt.prio;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result word and paces the ready line
    logic hold_done = 1'b0;
    int   hold_left = 0;

    always @(posedge i_clk) begin : monitor
        t_result want;
        int      idle_pct;
        idle_pct = (idle_mix == MIX_RX_SLOW) ? 75 : (idle_mix == MIX_TX_SLOW) ? 13 : 0;
        if (!i_rst_n) begin
            rcv_ready <= 1'b0;
        end else begin
            if (o_out_valid && rcv_ready) begin
                results_checked <= results_checked + 1;
                if (pq_results_due.size() == 0) begin
                    $error("unexpected result word: status %0d count %0d",
                           o_status, o_entry_count);
                    err_cnt++;
                end else begin
                    want = pq_results_due.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        err_cnt++;
                    end
                    if (o_removed_payload !== want.rem_payload) begin
                        $error("removed_payload: expected %08h, got %08h",
                               want.rem_payload, o_removed_payload);
                        err_cnt++;
                    end
                    if (o_removed_prio !== want.rem_prio) begin
                        $error("removed_prio: expected %0d, got %0d",
                               want.rem_prio, o_removed_prio);
                        err_cnt++;
                    end
                    if (o_head_payload !== want.head_payload) begin
                        $error("head_payload: expected %08h, got %08h",
                               want.head_payload, o_head_payload);
                        err_cnt++;
                    end
                    if (o_head_prio !== want.head_prio) begin
                        $error("head_prio: expected %0d, got %0d", want.head_prio, o_head_prio);
                        err_cnt++;
                    end
                    if (o_entry_count !== want.count) begin
                        $error("entry_count: expected %0d, got %0d", want.count, o_entry_count);
                        err_cnt++;
                    end
                    if (o_is_empty !== want.empty) begin
                        $error("is_empty: expected %0d, got %0d", want.empty, o_is_empty);
                        err_cnt++;
                    end
                end
            end
            // one long hold-off when idling stops, so the input side backs up
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                rcv_ready <= 1'b0;
            end else if (idle_mix == MIX_NO_IDLE && !hold_done) begin
                hold_left <= LONG_HOLD;
                hold_done <= 1'b1;
                rcv_ready <= 1'b0;
            end else begin
                rcv_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // Watchdog: too long without any word moving on either side
    int quiet_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if ((drv_valid && o_in_ready) || (o_out_valid && rcv_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Requests on an empty queue
        add_req(REQ_DEQ, 32'hFFFF_FFFF, PRIO_MAX);
        add_req(REQ_CLEAR, 32'h0000_0000, PRIO_MIN);
        add_req(REQ_UNUSED, 32'h5555_5555, 16'sh5555);
        // Fill to the brim: ties with the head and behind it, both extremes
        add_req(REQ_ENQ, 32'h0000_00A1, 16'sd5);
        add_req(REQ_ENQ, 32'h0000_00A2, 16'sd5);
        add_req(REQ_ENQ, 32'h0000_00A3, 16'sd5);
        add_req(REQ_ENQ, 32'h0000_0003, 16'sd3);
        add_req(REQ_ENQ, 32'h0000_0007, 16'sd7);
        add_req(REQ_ENQ, 32'hFFFF_FFFF, PRIO_MAX);
        add_req(REQ_ENQ, 32'h0000_0000, PRIO_MIN);
        add_req(REQ_ENQ, 32'hAAAA_AAAA, PRIO_MIN);
        add_req(REQ_ENQ, 32'h5555_5555, PRIO_MAX);
        add_req(REQ_ENQ, 32'h1234_5678, 16'sd0);
        add_req(REQ_ENQ, 32'h8765_4321, -16'sd1);
        add_req(REQ_ENQ, 32'h0F0F_0F0F, 16'sd1);
        add_req(REQ_ENQ, 32'hF0F0_F0F0, 16'sd5);
        add_req(REQ_ENQ, 32'h0000_0064, 16'sd100);
        add_req(REQ_ENQ, 32'hFFFF_FF9C, -16'sd100);
        add_req(REQ_ENQ, 32'h0000_0006, 16'sd6);
        // Full: rejected enqueue, no-op code, then dequeue and clear
        add_req(REQ_ENQ, 32'hDEAD_BEEF, PRIO_MIN);
        add_req(REQ_UNUSED, 32'hAAAA_AAAA, 16'shAAAA);
        add_req(REQ_DEQ, 32'h0000_0000, 16'sd0);
        add_req(REQ_CLEAR, 32'h0000_0000, 16'sd0);

        queue_random_words(200);
        while (words_taken != words_total) @(posedge i_clk);

        idle_mix <= MIX_TX_SLOW;
        queue_random_words(200);
        while (words_taken != words_total) @(posedge i_clk);

        idle_mix <= MIX_NO_IDLE;
        queue_random_words(200);
        while (results_checked != words_total) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pq_results_due.size() != 0)
            $error("%0d expected result words never arrived", pq_results_due.size());
        $display("Ran %0d request words: %0d enqueued, %0d refused as full, %0d dequeued,",
                 words_total, n_enq_ok, n_full, n_deq_ok);
        $display("%0d on empty, %0d clears, %0d no-op codes; deepest fill %0d of %0d",
                 n_on_empty, n_clear, n_unused, peak_len, QDEPTH);
        if (err_cnt == 0 && pq_results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
